[rtl/prps_pkg.sv]
// Shared types and constants for the post-code register poll sequencer.
// Used by prps_step and the top level; no dependencies.
`default_nettype none

package prps_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_STAGE_TIMEOUT = 3'd0,
		CFG_POINTER_BANK  = 3'd1,
		CFG_P80_PTR_REG   = 3'd2,
		CFG_P81_PTR_REG   = 3'd3,
		CFG_POST_DATA_BANK = 3'd4,
		CFG_P81_DATA_OR   = 3'd5
	} cfg_index_t;

	localparam int CFG_DATA_W = 10;

	// Configuration reset values
	localparam logic [9:0] RST_STAGE_TIMEOUT = 10'd100;
	localparam logic [7:0] RST_POINTER_BANK  = 8'h10;
	localparam logic [7:0] RST_P80_PTR_REG   = 8'hE3;
	localparam logic [7:0] RST_P81_PTR_REG   = 8'hE8;
	localparam logic [7:0] RST_POST_DATA_BANK = 8'h11;
	localparam logic [7:0] RST_P81_DATA_OR   = 8'h80;

	// Target register addresses on the chip
	localparam logic [7:0] ADDR_BANK  = 8'hFF;
	localparam logic [7:0] ADDR_INDEX = 8'hFE;
	localparam logic [7:0] ADDR_DATA  = 8'h00;

	typedef enum logic [2:0] {
		KIND_START_POLL = 3'd0,
		KIND_START_READ = 3'd1,
		KIND_WRITE_DONE = 3'd2,
		KIND_READ_DONE  = 3'd3,
		KIND_BUS_ERROR  = 3'd4,
		KIND_TICK       = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_REJECT = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_READ   = 3'd3,
		ACT_POLL   = 3'd4,
		ACT_SINGLE = 3'd5,
		ACT_FAIL   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_TIMEOUT = 2'd1,
		CAUSE_BUS     = 2'd2,
		CAUSE_ORDER   = 2'd3
	} cause_t;

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_PTR_BANK   = 7'b0000010,
		ST_PTR_INDEX  = 7'b0000100,
		ST_PTR_READ   = 7'b0001000,
		ST_DATA_BANK  = 7'b0010000,
		ST_DATA_INDEX = 7'b0100000,
		ST_CODE_READ  = 7'b1000000
	} step_t;

	typedef struct packed {
		logic [9:0] stage_timeout;
		logic [7:0] pointer_bank;
		logic [7:0] p80_ptr_reg;
		logic [7:0] p81_ptr_reg;
		logic [7:0] post_data_bank;
		logic [7:0] p81_data_or;
	} cfg_t;

	typedef struct packed {
		step_t      step;
		logic       on_port81;
		logic       combined_mode;
		logic [7:0] pointer_byte;
		logic [7:0] held_pointer80;
		logic [7:0] held_code80;
		logic [7:0] held_page;
		logic [7:0] held_index;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] page;
		logic [7:0] reg_index;
		logic [7:0] read_data;
	} event_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] reg_addr;
		logic [7:0] reg_value;
		cause_t     fail_cause;
		logic [7:0] pointer80;
		logic [7:0] code80;
		logic [7:0] pointer81;
		logic [7:0] code81;
		logic [7:0] sample_page;
		logic [7:0] sample_index;
		logic [7:0] sample_value;
	} result_t;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 80;

endpackage

`default_nettype wire

[rtl/prps_step.sv]
// Next-state and result logic for one event of the poll sequencer.
// Purely combinational; depends on prps_pkg.
`default_nettype none

module prps_step #(
	parameter int TIMER_BITS = 10
) (
	input  var prps_pkg::cfg_t       cfg,
	input  var prps_pkg::seq_state_t cur,
	input  wire [TIMER_BITS-1:0]     timer_cur,
	input  var prps_pkg::event_t     ev,
	output prps_pkg::seq_state_t     nxt,
	output logic [TIMER_BITS-1:0]    timer_nxt,
	output prps_pkg::result_t        res
);

	// compare width covers both the timer and the 10-bit timeout register
	localparam int CW = (TIMER_BITS > prps_pkg::CFG_DATA_W) ? TIMER_BITS : prps_pkg::CFG_DATA_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic [CW-1:0]         timeout_ext;
	logic [CW-1:0]         max_ext;
	logic [CW-1:0]         limit;
	logic [TIMER_BITS-1:0] timer_inc;
	logic [CW-1:0]         timer_inc_ext;
	logic [7:0]            hist_index;

	assign timeout_ext   = CW'(cfg.stage_timeout);
	assign max_ext       = CW'(TIMER_MAX);
	assign limit         = (timeout_ext < max_ext) ? timeout_ext : max_ext;
	assign timer_inc     = (timer_cur == TIMER_MAX) ? timer_cur : timer_cur + 1'b1;
	assign timer_inc_ext = CW'(timer_inc);

	// data index: pointer - 1, port 81 gets the mask; single read uses its own index
	always_comb begin
		if (cur.combined_mode) begin
			hist_index = cur.pointer_byte - 8'd1;
			if (cur.on_port81) begin
				hist_index = hist_index | cfg.p81_data_or;
			end
		end else begin
			hist_index = cur.held_index;
		end
	end

	always_comb begin
		nxt       = cur;
		timer_nxt = timer_cur;
		res       = '0;
		res.action     = prps_pkg::ACT_NONE;
		res.fail_cause = prps_pkg::CAUSE_NONE;

		unique case (ev.kind)
			prps_pkg::KIND_START_POLL: begin
				if (cur.step != prps_pkg::ST_IDLE) begin
					res.action = prps_pkg::ACT_REJECT;
				end else begin
					nxt.combined_mode = 1'b1;
					nxt.on_port81     = 1'b0;
					nxt.step          = prps_pkg::ST_PTR_BANK;
					timer_nxt         = '0;
					res.action        = prps_pkg::ACT_WRITE;
					res.reg_addr      = prps_pkg::ADDR_BANK;
					res.reg_value     = cfg.pointer_bank;
				end
			end
			prps_pkg::KIND_START_READ: begin
				if (cur.step != prps_pkg::ST_IDLE) begin
					res.action = prps_pkg::ACT_REJECT;
				end else begin
					nxt.combined_mode = 1'b0;
					nxt.on_port81     = 1'b0;
					nxt.held_page     = ev.page;
					nxt.held_index    = ev.reg_index;
					nxt.step          = prps_pkg::ST_DATA_BANK;
					timer_nxt         = '0;
					res.action        = prps_pkg::ACT_WRITE;
					res.reg_addr      = prps_pkg::ADDR_BANK;
					res.reg_value     = ev.page;
				end
			end
			prps_pkg::KIND_WRITE_DONE: begin
				unique case (cur.step)
					prps_pkg::ST_PTR_BANK: begin
						nxt.step      = prps_pkg::ST_PTR_INDEX;
						timer_nxt     = '0;
						res.action    = prps_pkg::ACT_WRITE;
						res.reg_addr  = prps_pkg::ADDR_INDEX;
						res.reg_value = cur.on_port81 ? cfg.p81_ptr_reg : cfg.p80_ptr_reg;
					end
					prps_pkg::ST_PTR_INDEX: begin
						nxt.step     = prps_pkg::ST_PTR_READ;
						timer_nxt    = '0;
						res.action   = prps_pkg::ACT_READ;
						res.reg_addr = prps_pkg::ADDR_DATA;
					end
					prps_pkg::ST_DATA_BANK: begin
						nxt.step      = prps_pkg::ST_DATA_INDEX;
						timer_nxt     = '0;
						res.action    = prps_pkg::ACT_WRITE;
						res.reg_addr  = prps_pkg::ADDR_INDEX;
						res.reg_value = hist_index;
					end
					prps_pkg::ST_DATA_INDEX: begin
						nxt.step     = prps_pkg::ST_CODE_READ;
						timer_nxt    = '0;
						res.action   = prps_pkg::ACT_READ;
						res.reg_addr = prps_pkg::ADDR_DATA;
					end
					default: begin
						nxt.step          = prps_pkg::ST_IDLE;
						nxt.on_port81     = 1'b0;
						nxt.combined_mode = 1'b0;
						timer_nxt         = '0;
						res.action        = prps_pkg::ACT_FAIL;
						res.fail_cause    = prps_pkg::CAUSE_ORDER;
					end
				endcase
			end
			prps_pkg::KIND_READ_DONE: begin
				unique case (cur.step)
					prps_pkg::ST_PTR_READ: begin
						nxt.pointer_byte = ev.read_data;
						nxt.step         = prps_pkg::ST_DATA_BANK;
						timer_nxt        = '0;
						res.action       = prps_pkg::ACT_WRITE;
						res.reg_addr     = prps_pkg::ADDR_BANK;
						res.reg_value    = cfg.post_data_bank;
					end
					prps_pkg::ST_CODE_READ: begin
						if (cur.combined_mode && !cur.on_port81) begin
							// port 80 done, hold its bytes and start port 81
							nxt.held_pointer80 = cur.pointer_byte;
							nxt.held_code80    = ev.read_data;
							nxt.on_port81      = 1'b1;
							nxt.step           = prps_pkg::ST_PTR_BANK;
							timer_nxt          = '0;
							res.action         = prps_pkg::ACT_WRITE;
							res.reg_addr       = prps_pkg::ADDR_BANK;
							res.reg_value      = cfg.pointer_bank;
						end else begin
							if (cur.combined_mode) begin
								res.action    = prps_pkg::ACT_POLL;
								res.pointer80 = cur.held_pointer80;
								res.code80    = cur.held_code80;
								res.pointer81 = cur.pointer_byte;
								res.code81    = ev.read_data;
							end else begin
								res.action       = prps_pkg::ACT_SINGLE;
								res.sample_page  = cur.held_page;
								res.sample_index = cur.held_index;
								res.sample_value = ev.read_data;
							end
							nxt.step          = prps_pkg::ST_IDLE;
							nxt.combined_mode = 1'b0;
							nxt.on_port81     = 1'b0;
							timer_nxt         = '0;
						end
					end
					default: begin
						nxt.step          = prps_pkg::ST_IDLE;
						nxt.on_port81     = 1'b0;
						nxt.combined_mode = 1'b0;
						timer_nxt         = '0;
						res.action        = prps_pkg::ACT_FAIL;
						res.fail_cause    = prps_pkg::CAUSE_ORDER;
					end
				endcase
			end
			prps_pkg::KIND_BUS_ERROR: begin
				nxt.step          = prps_pkg::ST_IDLE;
				nxt.on_port81     = 1'b0;
				nxt.combined_mode = 1'b0;
				timer_nxt         = '0;
				res.action        = prps_pkg::ACT_FAIL;
				res.fail_cause    = prps_pkg::CAUSE_BUS;
			end
			prps_pkg::KIND_TICK: begin
				if (cur.step != prps_pkg::ST_IDLE) begin
					if (timer_inc_ext >= limit) begin
						nxt.step          = prps_pkg::ST_IDLE;
						nxt.on_port81     = 1'b0;
						nxt.combined_mode = 1'b0;
						timer_nxt         = '0;
						res.action        = prps_pkg::ACT_FAIL;
						res.fail_cause    = prps_pkg::CAUSE_TIMEOUT;
					end else begin
						timer_nxt = timer_inc;
					end
				end
			end
			default: begin
				// unused kinds: no effect
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/postcode_register_poll_sequencer.sv]
// Top level of the post-code register poll sequencer: stream ports, config
// registers, input and result registers. Depends on prps_pkg and prps_step.
`default_nettype none

// Sequences register transactions to a post-code chip behind a bus engine.
// Each input item is an event (start poll, start read, write done, read done
// with its byte, bus error, millisecond tick); each event yields exactly one
// result item telling the bus engine what to issue next, or reporting a
// sample, a rejection or a failure. A poll reads pointer and code for port 80
// and then port 81 and reports all four bytes; a single read reports one byte
// at a given page and index. Throughput is one item per clock while the
// result stream keeps up: the event is captured in an input register, the
// sequencer state and the result are computed in one pass of short logic
// and loaded into the result register. While a result waits on the output
// the input register still takes one more item; after that the input stalls
// until the result is taken. Config writes are only legal while no item is
// in flight.

module postcode_register_poll_sequencer #(
	parameter int TIMER_BITS = 10
) (
	input  wire        clk,
	input  wire        arst_n,
	// config write port
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [prps_pkg::CFG_DATA_W-1:0] cfg_data,
	// event stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [prps_pkg::IN_TDATA_W-1:0] s_tdata, // page[7:0], reg_index[15:8], read_data[23:16]
	input  wire [2:0]  s_tuser,                     // kind[2:0]
	// result stream
	output logic       m_tvalid,
	input  wire        m_tready,
	// reg_addr[7:0], reg_value[15:8], fail_cause[17:16], pointer80[25:18], code80[33:26],
	// pointer81[41:34], code81[49:42], sample_page[57:50], sample_index[65:58],
	// sample_value[73:66], zero fill [79:74]
	output logic [prps_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [2:0] m_tuser                      // action[2:0]
);

	prps_pkg::cfg_t       cfg_q;
	prps_pkg::seq_state_t state_q;
	prps_pkg::seq_state_t state_nxt;
	logic [TIMER_BITS-1:0] timer_q;
	logic [TIMER_BITS-1:0] timer_nxt;

	logic              valid_s1;
	prps_pkg::event_t  ev_s1;
	prps_pkg::result_t res_nxt;
	prps_pkg::result_t res_q;
	logic              out_valid_q;

	logic in_fire;
	logic advance;

	// item in the input register moves on when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_fire  = s_tvalid && s_tready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_timeout  <= prps_pkg::RST_STAGE_TIMEOUT;
			cfg_q.pointer_bank   <= prps_pkg::RST_POINTER_BANK;
			cfg_q.p80_ptr_reg    <= prps_pkg::RST_P80_PTR_REG;
			cfg_q.p81_ptr_reg    <= prps_pkg::RST_P81_PTR_REG;
			cfg_q.post_data_bank <= prps_pkg::RST_POST_DATA_BANK;
			cfg_q.p81_data_or    <= prps_pkg::RST_P81_DATA_OR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prps_pkg::CFG_STAGE_TIMEOUT:  cfg_q.stage_timeout  <= cfg_data;
				prps_pkg::CFG_POINTER_BANK:   cfg_q.pointer_bank   <= cfg_data[7:0];
				prps_pkg::CFG_P80_PTR_REG:    cfg_q.p80_ptr_reg    <= cfg_data[7:0];
				prps_pkg::CFG_P81_PTR_REG:    cfg_q.p81_ptr_reg    <= cfg_data[7:0];
				prps_pkg::CFG_POST_DATA_BANK: cfg_q.post_data_bank <= cfg_data[7:0];
				prps_pkg::CFG_P81_DATA_OR:    cfg_q.p81_data_or    <= cfg_data[7:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ev_s1.kind      <= s_tuser;
			ev_s1.page      <= s_tdata[7:0];
			ev_s1.reg_index <= s_tdata[15:8];
			ev_s1.read_data <= s_tdata[23:16];
		end
	end

	prps_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.timer_cur (timer_q),
		.ev        (ev_s1),
		.nxt       (state_nxt),
		.timer_nxt (timer_nxt),
		.res       (res_nxt)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step           <= prps_pkg::ST_IDLE;
			state_q.on_port81      <= 1'b0;
			state_q.combined_mode  <= 1'b0;
			state_q.pointer_byte   <= '0;
			state_q.held_pointer80 <= '0;
			state_q.held_code80    <= '0;
			state_q.held_page      <= '0;
			state_q.held_index     <= '0;
			timer_q                <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			timer_q <= timer_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.action;
	assign m_tdata  = {
		6'd0,
		res_q.sample_value,
		res_q.sample_index,
		res_q.sample_page,
		res_q.code81,
		res_q.pointer81,
		res_q.code80,
		res_q.pointer80,
		res_q.fail_cause,
		res_q.reg_value,
		res_q.reg_addr
	};

endmodule

`default_nettype wire
